### src/mcs_pkg.sv
// shared types and constants for the minimum cut search block
package mcs_pkg;

   localparam int ReqRowBits   = 4;
   localparam int ReqColBits   = 4;
   localparam int ReqWeightBits = 16;
   localparam int CutValueBits = 22;
   localparam int SideMaskBits = 16;
   localparam int NodeCountBits = 5;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   localparam logic [NodeCountBits-1:0] NODE_COUNT_RESET = 5'd2;
   localparam logic [CutValueBits-1:0]  CUT_VALUE_MAX    = '1;

   typedef struct packed {
      logic                     opcode;
      logic [ReqRowBits-1:0]    row_node;
      logic [ReqColBits-1:0]    col_node;
      logic [ReqWeightBits-1:0] edge_weight;
   } mcs_req_type;

   typedef struct packed {
      logic [CutValueBits-1:0] min_cut_value;
      logic [SideMaskBits-1:0] side_mask;
      logic                    found;
   } mcs_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } mcs_state_type;

   // one matrix read issued by the sequencer
   typedef struct packed {
      logic valid;
      logic take;
      logic last_pair;
   } mcs_issue_type;

   // sequencer status toward the top level
   typedef struct packed {
      logic busy;
      logic start;
      logic done;
      logic found;
   } mcs_status_type;

endpackage

### src/mcs_weight_ram.sv
// weight matrix storage, one write port and one registered read port
module mcs_weight_ram import mcs_pkg::*; #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int Depth = 1 << ADDR_W;

   logic [DATA_W-1:0] mem_ff [0:Depth-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/mcs_cut_unit.sv
// shared accumulate and compare unit for cut sums
module mcs_cut_unit import mcs_pkg::*; #(
   parameter int MAX_NODES   = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  mcs_issue_type          issue,
   input  logic [MAX_NODES-1:0]   issue_mask,
   input  logic [WEIGHT_BITS-1:0] rd_data,
   output logic [WEIGHT_BITS+2*$clog2(MAX_NODES)-1:0] best_value,
   output logic [MAX_NODES-1:0]   best_mask
);

   localparam int IdxW = $clog2(MAX_NODES);
   localparam int SumW = WEIGHT_BITS + 2 * IdxW;

   mcs_issue_type        iss_ff;
   logic [MAX_NODES-1:0] iss_mask_ff;
   logic [SumW-1:0]      sum_ff, sum_in;
   logic [SumW-1:0]      best_ff, best_in;
   logic [MAX_NODES-1:0] best_mask_ff, best_mask_in;
   logic                 have_ff, have_in;
   logic [SumW-1:0]      total;

   // one add per matrix entry, one compare at the end of each mask
   always_comb begin
      total        = sum_ff + (iss_ff.take ? SumW'(rd_data) : '0);
      sum_in       = sum_ff;
      best_in      = best_ff;
      best_mask_in = best_mask_ff;
      have_in      = have_ff;
      if (start) begin
         sum_in  = '0;
         have_in = 1'b0;
      end else if (iss_ff.valid) begin
         sum_in = total;
         if (iss_ff.last_pair) begin
            sum_in = '0;
            if (!have_ff || (total < best_ff)) begin
               best_in      = total;
               best_mask_in = iss_mask_ff;
            end
            have_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff  <= '0;
         have_ff <= 1'b0;
      end else begin
         iss_ff  <= issue;
         have_ff <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_mask_ff  <= issue_mask;
      sum_ff       <= sum_in;
      best_ff      <= best_in;
      best_mask_ff <= best_mask_in;
   end

   assign best_value = best_ff;
   assign best_mask  = best_mask_ff;

endmodule

### src/mcs_sequencer.sv
// mask and node pair sequencer driving the matrix reads
module mcs_sequencer import mcs_pkg::*; #(
   parameter int MAX_NODES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           run_start,
   input  logic [NodeCountBits-1:0]       node_count,
   input  logic                           out_free,
   output logic                           rd_en,
   output logic [2*$clog2(MAX_NODES)-1:0] rd_addr,
   output mcs_issue_type                  issue,
   output logic [MAX_NODES-1:0]           issue_mask,
   output mcs_status_type                 status
);

   localparam int IdxW = $clog2(MAX_NODES);
   localparam int CntW = $clog2(MAX_NODES + 1);

   mcs_state_type        state_ff, state_in;
   logic [MAX_NODES-1:0] mask_ff, mask_in;
   logic [IdxW-1:0]      u_ff, u_in, v_ff, v_in;
   logic [CntW-1:0]      n_ff, n_in;
   logic                 found_ff, found_in;

   logic [CntW-1:0]      n_sat;
   logic [IdxW-1:0]      nm1;
   logic [MAX_NODES:0]   one_shift;
   logic [MAX_NODES-1:0] last_mask;
   logic                 v_last, last_pair, final_pair, take;

   always_comb begin
      n_sat      = (32'(node_count) > MAX_NODES) ? CntW'(MAX_NODES) : CntW'(node_count);
      nm1        = IdxW'(n_ff - CntW'(1));
      one_shift  = (MAX_NODES + 1)'(1) << n_ff;
      last_mask  = MAX_NODES'(one_shift - (MAX_NODES + 1)'(2));
      v_last     = (v_ff == nm1);
      last_pair  = v_last && (u_ff == nm1);
      final_pair = last_pair && (mask_ff == last_mask);
      take       = mask_ff[u_ff] & ~mask_ff[v_ff];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (run_start) begin
               state_in = (n_sat < CntW'(2)) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (final_pair) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // counters
   always_comb begin
      mask_in  = mask_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      n_in     = n_ff;
      found_in = found_ff;
      if ((state_ff == ST_IDLE) && run_start) begin
         n_in     = n_sat;
         mask_in  = MAX_NODES'(1);
         u_in     = '0;
         v_in     = '0;
         found_in = (n_sat >= CntW'(2));
      end else if (state_ff == ST_SCAN) begin
         if (v_last) begin
            v_in = '0;
            if (last_pair) begin
               u_in    = '0;
               mask_in = mask_ff + MAX_NODES'(1);
            end else begin
               u_in = u_ff + IdxW'(1);
            end
         end else begin
            v_in = v_ff + IdxW'(1);
         end
      end
   end

   // outputs
   always_comb begin
      rd_en           = (state_ff == ST_SCAN);
      rd_addr         = {u_ff, v_ff};
      issue.valid     = (state_ff == ST_SCAN);
      issue.take      = take;
      issue.last_pair = last_pair;
      issue_mask      = mask_ff;
      status.busy     = (state_ff != ST_IDLE);
      status.start    = (state_ff == ST_IDLE) && run_start;
      status.done     = (state_ff == ST_DONE);
      status.found    = found_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      n_ff    <= n_in;
   end

`ifndef NO_ASSERTIONS
   a_scan_found : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> found_ff)
      else $error("scan running without a proper bipartition");

   a_pair_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((32'(u_ff) < 32'(n_ff)) && (32'(v_ff) < 32'(n_ff))))
      else $error("node pair outside the active nodes");

   a_drain_done : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_DONE))
      else $error("drain not followed by done");
`endif

endmodule

### src/exhaustive_min_cut_search.sv
// top level of the exhaustive minimum cut search block
//
// usage
//   req channel: one word per item, valid/stall handshake. a load word
//   (opcode load) writes one directed edge weight into the matrix;
//   loads to a node index at or above MAX_NODES are dropped. a run word
//   starts the search over the first node_count nodes.
//   rsp channel: one word per run word, none per load word.
//   csr port: csr_write with csr_data sets node_count; write only while idle.
// search order
//   a run word scans every node pair of each mask, for masks 1 .. 2^n-2,
//   then drains the matrix read and the final compare; the single shared
//   adder/comparator fed by the one matrix read port sums the pairs in turn.
//   with fewer than two nodes no scan runs and the result has found low.
//   req_stall stays high for the whole search.
// reset
//   synchronous, active high: node_count returns to 2, the sequencer goes
//   idle, rsp_valid drops. the weight matrix keeps no reset value.
// stall
//   a finished result sits in the output register while rsp_stall is high;
//   load words are still taken meanwhile, and a later search waits at its end
//   until the output register is free.
module exhaustive_min_cut_search import mcs_pkg::*; #(
   parameter int MAX_NODES   = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mcs_req_type              req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mcs_rsp_type              rsp_word,
   input  logic                     csr_write,
   input  logic [NodeCountBits-1:0] csr_data
);

   localparam int IdxW  = $clog2(MAX_NODES);
   localparam int AddrW = 2 * IdxW;
   localparam int SumW  = WEIGHT_BITS + 2 * IdxW;

   logic [NodeCountBits-1:0] node_count_ff;

   // handshake and load decode
   logic req_accept, load_en, run_start, out_free, out_load;
   logic [IdxW-1:0]        wr_row, wr_col;
   logic [WEIGHT_BITS-1:0] wr_data;

   // sequencer to ram and cut unit
   logic                 rd_en;
   logic [AddrW-1:0]     rd_addr;
   logic [WEIGHT_BITS-1:0] rd_data;
   mcs_issue_type        issue;
   logic [MAX_NODES-1:0] issue_mask;
   mcs_status_type       status;
   logic [SumW-1:0]      best_value;
   logic [MAX_NODES-1:0] best_mask;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   mcs_rsp_type rsp_word_ff, rsp_word_in;
   logic        value_sat;

   // node count register
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_write) begin
         node_count_ff <= csr_data;
      end
   end

   assign req_stall  = status.busy;
   assign req_accept = req_valid && !req_stall;
   assign run_start  = req_accept && (req_word.opcode == OP_RUN);

   // loads beyond the matrix are dropped
   always_comb begin
      load_en = req_accept && (req_word.opcode == OP_LOAD)
                && (32'(req_word.row_node) < MAX_NODES)
                && (32'(req_word.col_node) < MAX_NODES);
      wr_row  = IdxW'(32'(req_word.row_node));
      wr_col  = IdxW'(32'(req_word.col_node));
      wr_data = WEIGHT_BITS'(32'(req_word.edge_weight));
   end

   mcs_weight_ram #(
      .ADDR_W (AddrW),
      .DATA_W (WEIGHT_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr ({wr_row, wr_col}),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mcs_sequencer #(
      .MAX_NODES (MAX_NODES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .run_start  (run_start),
      .node_count (node_count_ff),
      .out_free   (out_free),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .issue      (issue),
      .issue_mask (issue_mask),
      .status     (status)
   );

   mcs_cut_unit #(
      .MAX_NODES   (MAX_NODES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_cut (
      .clock      (clock),
      .reset      (reset),
      .start      (status.start),
      .issue      (issue),
      .issue_mask (issue_mask),
      .rd_data    (rd_data),
      .best_value (best_value),
      .best_mask  (best_mask)
   );

   // result word: saturate the sum, zeros when no bipartition exists
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      out_load     = status.done && out_free;
      value_sat    = (SumW > CutValueBits) && (best_value > SumW'(CUT_VALUE_MAX));
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.found         = status.found;
         rsp_word_in.min_cut_value = '0;
         rsp_word_in.side_mask     = '0;
         if (status.found) begin
            rsp_word_in.min_cut_value = value_sat ? CUT_VALUE_MAX
                                                  : CutValueBits'(best_value);
            rsp_word_in.side_mask     = SideMaskBits'(best_mask);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(status.done))
      else $error("result word raised without a finished search");
`endif

endmodule
